// ----- hw/rtl/ucdp_pkg.sv -----
package ucdp_pkg;

    // descriptor type codes
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

    // minimum lengths
    localparam logic [7:0] MIN_DESC_LEN      = 8'd2;
    localparam logic [7:0] MIN_INTERFACE_LEN = 8'd9;
    localparam logic [7:0] MIN_ENDPOINT_LEN  = 8'd7;

    // configuration header is always nine bytes, last index is eight
    localparam logic [7:0] HEADER_LAST_IDX = 8'd8;

    // record kinds
    localparam logic [2:0] KIND_CONFIG       = 3'd0;
    localparam logic [2:0] KIND_INTERFACE    = 3'd1;
    localparam logic [2:0] KIND_ENDPOINT     = 3'd2;
    localparam logic [2:0] KIND_OTHER_CONFIG = 3'd3;
    localparam logic [2:0] KIND_OTHER_INTF   = 3'd4;
    localparam logic [2:0] KIND_VERDICT      = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_EARLY_INTF    = 3'd1;
    localparam logic [2:0] ERR_STRAY_EP      = 3'd2;
    localparam logic [2:0] ERR_MISSING_EP    = 3'd3;
    localparam logic [2:0] ERR_BAD_LENGTH    = 3'd4;
    localparam logic [2:0] ERR_TOO_MANY_INTF = 3'd5;

    // queue depths
    localparam int TAG_QUEUE_DEPTH    = 4;
    localparam int RESULT_QUEUE_DEPTH = 2;

    // one input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // one result record
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] desc_type;
        logic [7:0] descriptor_length;
        logic [7:0] interface_index;
        logic [7:0] endpoint_index;
        logic       error;
        logic [2:0] error_code;
        logic       final_res;
    } result_t;

    // byte tagged with its position inside the current descriptor
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       in_header;
        logic       pos_length;
        logic       pos_type;
        logic       pos_four;
        logic       complete;
    } tag_t;

endpackage

// ----- hw/rtl/usb_config_descriptor_parser.sv -----
// channel  | handshake         | payload   | transfer when
// ---------+-------------------+-----------+-------------------------
// input    | push / full       | item      | push && !full
// result   | empty / pop       | result    | pop && !empty
//
// one byte per cycle sustained while full stays low; at most one result per byte.
// a byte is tagged by the front on entry and held in the tag queue, walked by
// the back when it leaves that queue, and its result is registered in the
// result queue before it shows on the ports.
// full rises only when the tag queue (TAG_DEPTH entries) backs up behind a
// stalled result queue; reset empties both queues and starts at the header.
module usb_config_descriptor_parser
    import ucdp_pkg::*;
#(
    parameter int TAG_DEPTH = TAG_QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     empty,
    input  logic     pop,
    output result_t  result
);

    tag_t    front_tag, back_tag;
    result_t back_res;
    logic    tq_empty, tq_pop;
    logic    rq_full, rq_push;

    // front: tag incoming bytes
    ucdp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push && !full),
        .item   (item),
        .tag    (front_tag)
    );

    // queue between front and back
    ucdp_fifo #(
        .WIDTH ($bits(tag_t)),
        .DEPTH (TAG_DEPTH)
    ) u_tag_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_tag),
        .full  (full),
        .pop   (tq_pop),
        .rdata (back_tag),
        .empty (tq_empty)
    );

    // back: descriptor walker and checks
    ucdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_valid (!tq_empty),
        .tag       (back_tag),
        .tag_take  (tq_pop),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res       (back_res)
    );

    // result queue toward the consumer
    ucdp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (back_res),
        .full  (rq_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ----- hw/rtl/ucdp_fifo.sv -----
module ucdp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hw/rtl/ucdp_front.sv -----
module ucdp_front
    import ucdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output tag_t     tag
);

    logic       hdr_reg, hdr_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] len_reg, len_next;
    logic       complete;

    // classify the byte by its position
    always_comb
    begin
        hdr_next = hdr_reg;
        idx_next = idx_reg;
        len_next = len_reg;
        complete = 1'b0;
        if (hdr_reg)
        begin
            complete = (idx_reg == HEADER_LAST_IDX);
            if (complete)
            begin
                hdr_next = 1'b0;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (idx_reg == '0)
        begin
            len_next = item.data_byte;
            idx_next = 8'd1;
        end
        else
        begin
            complete = ({1'b0, idx_reg} + 9'd1) >= {1'b0, len_reg};
            idx_next = complete ? '0 : idx_reg + 1'b1;
        end
        // block ends, start over at the header
        if (item.last_byte)
        begin
            hdr_next = 1'b1;
            idx_next = '0;
            len_next = '0;
        end
    end

    assign tag.data_byte  = item.data_byte;
    assign tag.last_byte  = item.last_byte;
    assign tag.in_header  = hdr_reg;
    assign tag.pos_length = (idx_reg == 8'd0);
    assign tag.pos_type   = (idx_reg == 8'd1);
    assign tag.pos_four   = (idx_reg == 8'd4);
    assign tag.complete   = complete;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= 1'b1;
            idx_reg <= '0;
            len_reg <= '0;
        end
        else if (accept)
        begin
            hdr_reg <= hdr_next;
            idx_reg <= idx_next;
            len_reg <= len_next;
        end
    end

endmodule

// ----- hw/rtl/ucdp_back.sv -----
module ucdp_back
    import ucdp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tag_valid,
    input  tag_t    tag,
    output logic    tag_take,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    logic [7:0] cl_reg,   cl_next;
    logic [7:0] ct_reg,   ct_next;
    logic [7:0] itot_reg, itot_next;
    logic [7:0] ifn_reg,  ifn_next;
    logic [7:0] epc_reg,  epc_next;
    logic [7:0] epx_reg,  epx_next;
    logic       seen_reg, seen_next;
    logic [2:0] err_reg,  err_next;
    logic       emit;
    logic [2:0] kind;
    logic [7:0] ep_idx;
    logic [8:0] ifn_cand;

    assign tag_take = tag_valid && !res_full;
    assign res_push = tag_take && (emit || tag.last_byte);
    assign ifn_cand = seen_reg ? {1'b0, ifn_reg} + 9'd1 : 9'd0;

    // walk the descriptor chain one byte at a time
    always_comb
    begin
        cl_next   = cl_reg;
        ct_next   = ct_reg;
        itot_next = itot_reg;
        ifn_next  = ifn_reg;
        epc_next  = epc_reg;
        epx_next  = epx_reg;
        seen_next = seen_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        kind      = KIND_VERDICT;
        ep_idx    = '0;
        if (err_reg == ERR_NONE)
        begin
            if (tag.in_header)
            begin
                if (tag.pos_length)
                begin
                    cl_next = tag.data_byte;
                end
                if (tag.pos_type)
                begin
                    ct_next = tag.data_byte;
                end
                if (tag.pos_four)
                begin
                    itot_next = tag.data_byte;
                end
                if (tag.complete)
                begin
                    emit = 1'b1;
                    kind = KIND_CONFIG;
                end
            end
            else if (tag.pos_length)
            begin
                cl_next = tag.data_byte;
                if (tag.data_byte < MIN_DESC_LEN)
                begin
                    err_next = ERR_BAD_LENGTH;
                end
            end
            else
            begin
                // structural checks on the type byte
                if (tag.pos_type)
                begin
                    ct_next = tag.data_byte;
                    if (tag.data_byte == TYPE_INTERFACE)
                    begin
                        if (cl_reg < MIN_INTERFACE_LEN)
                        begin
                            err_next = ERR_BAD_LENGTH;
                        end
                        else if (seen_reg && (epc_reg != epx_reg))
                        begin
                            err_next = ERR_EARLY_INTF;
                        end
                        else if (ifn_cand >= {1'b0, itot_reg})
                        begin
                            err_next = ERR_TOO_MANY_INTF;
                        end
                        else
                        begin
                            ifn_next  = ifn_cand[7:0];
                            seen_next = 1'b1;
                            epc_next  = '0;
                            epx_next  = '0;
                        end
                    end
                    else if (tag.data_byte == TYPE_ENDPOINT)
                    begin
                        if (cl_reg < MIN_ENDPOINT_LEN)
                        begin
                            err_next = ERR_BAD_LENGTH;
                        end
                        else if (!seen_reg || (epc_reg == epx_reg))
                        begin
                            err_next = ERR_STRAY_EP;
                        end
                        else
                        begin
                            epc_next = epc_reg + 1'b1;
                        end
                    end
                end
                else if (tag.pos_four && (ct_reg == TYPE_INTERFACE))
                begin
                    epx_next = tag.data_byte;
                end
                // record for a completed descriptor
                if ((err_next == ERR_NONE) && tag.complete)
                begin
                    emit = 1'b1;
                    if (ct_next == TYPE_INTERFACE)
                    begin
                        kind = KIND_INTERFACE;
                    end
                    else if (ct_next == TYPE_ENDPOINT)
                    begin
                        kind   = KIND_ENDPOINT;
                        ep_idx = epc_next - 1'b1;
                    end
                    else
                    begin
                        kind = seen_next ? KIND_OTHER_INTF : KIND_OTHER_CONFIG;
                    end
                end
            end
        end
        // verdict checks on the last byte
        if (tag.last_byte && (err_next == ERR_NONE))
        begin
            if (!tag.complete)
            begin
                err_next = ERR_BAD_LENGTH;
            end
            else if (seen_next && (epc_next != epx_next))
            begin
                err_next = ERR_MISSING_EP;
            end
        end
    end

    assign res.kind              = kind;
    assign res.desc_type         = emit ? ct_next : 8'd0;
    assign res.descriptor_length = emit ? cl_next : 8'd0;
    assign res.interface_index   = ifn_next;
    assign res.endpoint_index    = ep_idx;
    assign res.error             = (err_next != ERR_NONE);
    assign res.error_code        = err_next;
    assign res.final_res         = tag.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_reg   <= '0;
            ct_reg   <= '0;
            itot_reg <= '0;
            ifn_reg  <= '0;
            epc_reg  <= '0;
            epx_reg  <= '0;
            seen_reg <= 1'b0;
            err_reg  <= ERR_NONE;
        end
        else if (tag_take)
        begin
            if (tag.last_byte)
            begin
                cl_reg   <= '0;
                ct_reg   <= '0;
                itot_reg <= '0;
                ifn_reg  <= '0;
                epc_reg  <= '0;
                epx_reg  <= '0;
                seen_reg <= 1'b0;
                err_reg  <= ERR_NONE;
            end
            else
            begin
                cl_reg   <= cl_next;
                ct_reg   <= ct_next;
                itot_reg <= itot_next;
                ifn_reg  <= ifn_next;
                epc_reg  <= epc_next;
                epx_reg  <= epx_next;
                seen_reg <= seen_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

// ----- hw/rtl/ucdp_checker.sv -----
module ucdp_checker
    import ucdp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     empty,
    input logic     pop,
    input result_t  result
);

    // verdict-only records appear only on the final result
    a_verdict_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_VERDICT)) |-> result.final_res)
        else $error("verdict-only record without final flag");

    // verdict-only records carry no descriptor bytes
    a_verdict_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_VERDICT))
            |-> ((result.desc_type == 8'd0) && (result.descriptor_length == 8'd0)))
        else $error("verdict-only record carries descriptor bytes");

    // error flag agrees with the code
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.error == (result.error_code != ERR_NONE)))
        else $error("error flag and error code disagree");

    // endpoint records carry the endpoint type
    a_endpoint_type: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_ENDPOINT))
            |-> (result.desc_type == TYPE_ENDPOINT))
        else $error("endpoint record with wrong descriptor type");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before transfer");

endmodule

bind usb_config_descriptor_parser ucdp_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ----- tb/ucdp_record_checker.sv -----
module ucdp_record_checker
    import ucdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  in_item_t item,
    input  logic     empty,
    input  logic     pop,
    input  result_t  result,
    output int       mismatches,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the descriptor walker
    logic [7:0] pos_in_desc;
    logic [7:0] cur_len;
    logic [7:0] cur_type;
    logic       hdr_phase;
    logic [7:0] intf_total;
    logic [7:0] intf_num;
    logic [7:0] ep_count;
    logic [7:0] ep_expected;
    logic       have_intf;
    logic [2:0] err_latched;

    // records still owed by the parser, oldest first
    result_t owed_records[$];
    int      fail_count;
    result_t want;
    result_t walked;
    bit      walked_valid;

    task automatic clear_walker();
        pos_in_desc = 8'd0;
        cur_len     = 8'd0;
        cur_type    = 8'd0;
        hdr_phase   = 1'b1;
        intf_total  = 8'd0;
        intf_num    = 8'd0;
        ep_count    = 8'd0;
        ep_expected = 8'd0;
        have_intf   = 1'b0;
        err_latched = ERR_NONE;
    endtask

    // advance the walker by one byte and build the record it yields, if any
    task automatic walk_byte(input in_item_t it, output bit emit, output result_t rec);
        logic [7:0] d;
        logic [2:0] knd;
        logic [7:0] ep_idx;
        int         nxt;
        d      = it.data_byte;
        emit   = 1'b0;
        knd    = KIND_VERDICT;
        ep_idx = 8'd0;
        if (err_latched == ERR_NONE) begin
            if (hdr_phase) begin
                // fixed nine byte configuration header
                if (pos_in_desc == 8'd0) cur_len = d;
                if (pos_in_desc == 8'd1) cur_type = d;
                if (pos_in_desc == 8'd4) intf_total = d;
                if (pos_in_desc >= HEADER_LAST_IDX) begin
                    emit        = 1'b1;
                    knd         = KIND_CONFIG;
                    hdr_phase   = 1'b0;
                    pos_in_desc = 8'd0;
                end
                else begin
                    pos_in_desc++;
                end
            end
            else if (pos_in_desc == 8'd0) begin
                // length byte of a chained descriptor
                cur_len = d;
                if (d < MIN_DESC_LEN)
                    err_latched = ERR_BAD_LENGTH;
                else
                    pos_in_desc = 8'd1;
            end
            else begin
                if (pos_in_desc == 8'd1) begin
                    // structural checks on the type byte
                    cur_type = d;
                    if (cur_type == TYPE_INTERFACE) begin
                        if (cur_len < MIN_INTERFACE_LEN) begin
                            err_latched = ERR_BAD_LENGTH;
                        end
                        else if (have_intf && ep_count != ep_expected) begin
                            err_latched = ERR_EARLY_INTF;
                        end
                        else begin
                            nxt = have_intf ? int'(intf_num) + 1 : 0;
                            if (nxt >= int'(intf_total)) begin
                                err_latched = ERR_TOO_MANY_INTF;
                            end
                            else begin
                                intf_num    = nxt[7:0];
                                have_intf   = 1'b1;
                                ep_count    = 8'd0;
                                ep_expected = 8'd0;
                            end
                        end
                    end
                    else if (cur_type == TYPE_ENDPOINT) begin
                        if (cur_len < MIN_ENDPOINT_LEN)
                            err_latched = ERR_BAD_LENGTH;
                        else if (!have_intf || ep_count == ep_expected)
                            err_latched = ERR_STRAY_EP;
                        else
                            ep_count = ep_count + 8'd1;
                    end
                end
                else if (pos_in_desc == 8'd4 && cur_type == TYPE_INTERFACE) begin
                    ep_expected = d;
                end
                if (err_latched == ERR_NONE) begin
                    if (int'(pos_in_desc) + 1 >= int'(cur_len)) begin
                        emit = 1'b1;
                        if (cur_type == TYPE_INTERFACE) begin
                            knd = KIND_INTERFACE;
                        end
                        else if (cur_type == TYPE_ENDPOINT) begin
                            knd    = KIND_ENDPOINT;
                            ep_idx = ep_count - 8'd1;
                        end
                        else begin
                            knd = have_intf ? KIND_OTHER_INTF : KIND_OTHER_CONFIG;
                        end
                        pos_in_desc = 8'd0;
                    end
                    else begin
                        pos_in_desc++;
                    end
                end
            end
        end
        // end of block: truncation and missing endpoint checks
        if (it.last_byte && err_latched == ERR_NONE) begin
            if (hdr_phase || pos_in_desc != 8'd0)
                err_latched = ERR_BAD_LENGTH;
            else if (have_intf && ep_count != ep_expected)
                err_latched = ERR_MISSING_EP;
        end
        rec.kind              = knd;
        rec.desc_type         = emit ? cur_type : 8'd0;
        rec.descriptor_length = emit ? cur_len : 8'd0;
        rec.interface_index   = intf_num;
        rec.endpoint_index    = ep_idx;
        rec.error             = (err_latched != ERR_NONE);
        rec.error_code        = err_latched;
        rec.final_res         = it.last_byte;
        if (it.last_byte) begin
            emit = 1'b1;
            clear_walker();
        end
    endtask

    // compare result transfers against the oldest owed record, then predict
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_walker();
            owed_records = {};
            fail_count   = 0;
            mismatches  <= 0;
            pending     <= 0;
        end
        else begin
            if (pop && !empty) begin
                if (owed_records.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected record at %0t: kind %0d type %h len %h final %b",
                                 $realtime, result.kind, result.desc_type,
                                 result.descriptor_length, result.final_res);
                    fail_count++;
                end
                else begin
                    want = owed_records.pop_front();
                    if (result.kind !== want.kind
                        || result.desc_type !== want.desc_type
                        || result.descriptor_length !== want.descriptor_length
                        || result.interface_index !== want.interface_index
                        || result.endpoint_index !== want.endpoint_index
                        || result.error !== want.error
                        || result.error_code !== want.error_code
                        || result.final_res !== want.final_res) begin
                        if (fail_count < 10)
                            $display({"record mismatch at %0t (expected/actual): kind %0d/%0d",
                                      " type %h/%h len %h/%h intf %0d/%0d ep %0d/%0d",
                                      " err %b/%b code %0d/%0d final %b/%b"},
                                     $realtime, want.kind, result.kind,
                                     want.desc_type, result.desc_type,
                                     want.descriptor_length, result.descriptor_length,
                                     want.interface_index, result.interface_index,
                                     want.endpoint_index, result.endpoint_index,
                                     want.error, result.error,
                                     want.error_code, result.error_code,
                                     want.final_res, result.final_res);
                        fail_count++;
                    end
                end
            end
            if (push && !full) begin
                walk_byte(item, walked_valid, walked);
                if (walked_valid)
                    owed_records.push_back(walked);
            end
            mismatches <= fail_count;
            pending    <= owed_records.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import ucdp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1600;
    localparam int IDLE_LIMIT  = 2000;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     push  = 1'b0;
    logic     full;
    in_item_t item  = '0;
    logic     empty;
    logic     pop   = 1'b0;
    result_t  result;
    int       mismatches;
    int       pending;

    // current descriptor block being built
    logic [7:0] blk[$];
    int         bytes_sent = 0;
    int         idle_cycles = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    always #5 clk = ~clk;

    usb_config_descriptor_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    ucdp_record_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // one byte transfer, with a random gap in front
    task automatic send_byte(input logic [7:0] d, input logic lst);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        item.data_byte <= d;
        item.last_byte <= lst;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < blk.size(); i++)
            send_byte(blk[i], i == blk.size() - 1);
    endtask

    // stop sending until every owed record has come back
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic add_desc(input int len, input logic [7:0] typ, input logic [7:0] b4);
        blk.push_back(len[7:0]);
        blk.push_back(typ);
        for (int k = 2; k < len; k++)
            blk.push_back(k == 4 ? b4 : 8'($urandom_range(0, 255)));
    endtask

    task automatic add_other();
        logic [7:0] t;
        do t = 8'($urandom_range(0, 255)); while (t == TYPE_INTERFACE || t == TYPE_ENDPOINT);
        add_desc($urandom_range(2, 8), t, 8'($urandom_range(0, 255)));
    endtask

    // well-formed configuration block with random content
    task automatic make_config_block();
        int         n_build;
        int         n_ep;
        logic [7:0] intf_field;
        blk = {};
        intf_field = 8'($urandom_range(1, 3));
        if ($urandom_range(0, 15) == 0)
            intf_field = 8'($urandom_range(0, 255));
        n_build = (intf_field > 3) ? 3 : int'(intf_field);
        n_build = $urandom_range(0, n_build);
        blk.push_back($urandom_range(0, 1) ? 8'd9 : 8'($urandom_range(0, 255)));
        blk.push_back($urandom_range(0, 1) ? 8'd2 : 8'($urandom_range(0, 255)));
        blk.push_back(8'($urandom_range(0, 255)));
        blk.push_back(8'($urandom_range(0, 255)));
        blk.push_back(intf_field);
        repeat (4) blk.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            add_other();
        for (int i = 0; i < n_build; i++) begin
            n_ep = $urandom_range(0, 3);
            add_desc($urandom_range(0, 3) == 0 ? $urandom_range(9, 12) : 9,
                     TYPE_INTERFACE, 8'(n_ep));
            if ($urandom_range(0, 2) == 0)
                add_other();
            for (int j = 0; j < n_ep; j++)
                add_desc($urandom_range(0, 3) == 0 ? $urandom_range(7, 9) : 7,
                         TYPE_ENDPOINT, 8'($urandom_range(0, 255)));
        end
    endtask

    // change a well-formed block in one place, so that it may break
    task automatic mutate_block();
        int pick;
        int idx;
        int t;
        pick = $urandom_range(0, 3);
        case (pick)
            0: begin
                idx = $urandom_range(0, blk.size() - 2);
                blk = blk[0:idx];
            end
            1: begin
                idx = $urandom_range(0, blk.size() - 1);
                t   = $urandom_range(0, 4);
                blk[idx] = (t == 0) ? 8'd0 : (t == 1) ? 8'd1 : (t == 2) ? TYPE_INTERFACE :
                           (t == 3) ? TYPE_ENDPOINT : 8'($urandom_range(0, 255));
            end
            2: add_desc($urandom_range(2, 9), TYPE_ENDPOINT, 8'($urandom_range(0, 255)));
            default: add_desc($urandom_range(7, 10), TYPE_INTERFACE, 8'($urandom_range(0, 2)));
        endcase
    endtask

    // result side: random pop gaps with calm stretches
    initial
    begin : result_sink
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        int sel;
        int blocks;
        blocks = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // truncated inside the header
        blk = {8'hFF, 8'h00};
        send_block();
        // no interfaces allowed, then an interface
        blk = {8'h09, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h09, TYPE_INTERFACE, 8'hFF};
        send_block();
        // block ending right on the header
        blk = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_block();
        drain();

        // random blocks: mostly well-formed, some broken, some noise
        while (bytes_sent < BYTE_TARGET) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                make_config_block();
            end
            else if (sel < 9) begin
                make_config_block();
                mutate_block();
            end
            else begin
                blk = {};
                repeat ($urandom_range(1, 30)) blk.push_back(8'($urandom_range(0, 255)));
            end
            send_block();
            blocks++;
            if (blocks % 37 == 0)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
